### rtl/alfio_pkg.sv
// Shared types, constants and sample arithmetic for the fade block.
`default_nettype none
package alfio_pkg;

    localparam int DELAY_DEPTH_DEF   = 4096;
    localparam int GAIN_ROM_BITS_DEF = 10;
    localparam int MAX_CHANNELS      = 4;
    localparam int LANES             = 4;
    localparam int SW                = 16;

    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_S8  = 2'd1;
    localparam logic [1:0] FMT_U16 = 2'd2;
    localparam logic [1:0] FMT_S16 = 2'd3;

    localparam logic [2:0] CFG_CHANNELS = 3'd0;
    localparam logic [2:0] CFG_FORMAT   = 3'd1;
    localparam logic [2:0] CFG_FI_LEN   = 3'd2;
    localparam logic [2:0] CFG_FO_LEN   = 3'd3;
    localparam logic [2:0] CFG_FI_STEP  = 3'd4;
    localparam logic [2:0] CFG_FO_STEP  = 3'd5;

    localparam logic [16:0] GAIN_ONE    = 17'd65536;
    localparam logic [24:0] UNITY_PHASE = 25'd16777216;
    localparam logic [24:0] LIN_LIMIT   = 25'd1677722;
    localparam logic [15:0] LIN_SLOPE   = 16'd41943;
    localparam logic [24:0] PHASE_MAX   = 25'h1FFFFFF;
    localparam logic [16:0] POS_MAX     = 17'h1FFFF;

    typedef struct packed {
        logic [2:0]  channel_count;
        logic [1:0]  sample_format;
        logic [15:0] fade_in_length;
        logic [12:0] fade_out_length;
        logic [24:0] fade_in_phase_step;
        logic [24:0] fade_out_phase_step;
    } t_cfg;

    function automatic logic [2:0] eff_channels(logic [2:0] c);
        logic [2:0] r;
        r = c;
        if (r == 3'd0) r = 3'd1;
        if (r > 3'(MAX_CHANNELS)) r = 3'(MAX_CHANNELS);
        return r;
    endfunction

    function automatic logic [15:0] decode(logic [15:0] w, logic [1:0] fmt);
        logic [15:0] r;
        unique case (fmt)
            FMT_U8:  r = {~w[7], w[6:0], 8'h00};
            FMT_S8:  r = {w[7:0], 8'h00};
            FMT_U16: r = {~w[15], w[14:0]};
            default: r = w;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] apply_gain(logic [15:0] v, logic [16:0] g);
        logic [15:0] m;
        logic [32:0] p;
        logic [16:0] q;
        m = v[15] ? 16'(-v) : v;
        p = {17'd0, m} * {16'd0, g};
        q = p[32:16];
        return v[15] ? 16'(-q) : q[15:0];
    endfunction

    function automatic logic [15:0] encode(logic [15:0] v, logic [1:0] fmt);
        logic        sgn;
        logic        wrd;
        logic [15:0] m;
        logic [14:0] k;
        logic [30:0] prod;
        logic [30:0] up;
        logic [15:0] q;
        logic [15:0] s;
        logic [15:0] r;
        sgn  = (fmt == FMT_S8) || (fmt == FMT_S16);
        wrd  = (fmt == FMT_U16) || (fmt == FMT_S16);
        m    = v[15] ? 16'(-v) : v;
        k    = wrd ? 15'd32767 : 15'd127;
        prod = {15'd0, m} * {16'd0, k};
        up   = (v[15] && !sgn) ? prod + 31'd32767 : prod;
        q    = up[30:15];
        s    = v[15] ? 16'(-q) : q;
        r    = sgn ? s : s + (wrd ? 16'h8000 : 16'h0080);
        return wrd ? r : {8'h00, r[7:0]};
    endfunction

    // exp(-x) series per ROM entry, evaluated at elaboration only
    function automatic logic [16:0] gain_rom_entry(int unsigned k, int unsigned bits);
        logic [63:0] q;
        logic [63:0] t;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] e;
        q    = (64'd1 << bits) - 64'(k);
        t    = (q * 64'd725686) >> bits;
        x    = ((t & 64'hFFFF) * 64'd45426) >> 16;
        term = 64'd1 << 30;
        pos  = term;
        neg  = 64'd0;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * x) >> 16) / 64'(n);
            if (n % 2 == 1) neg = neg + term;
            else pos = pos + term;
        end
        e = ((pos - neg) >> 14) >> (t >> 16);
        return e[16:0];
    endfunction

endpackage
`default_nettype wire

### rtl/alfio_cmdq.sv
// Two-entry command queue between the front and back parts.
`default_nettype none
module alfio_cmdq #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wr <= ~r_wr;
            if (do_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule
`default_nettype wire

### rtl/alfio_front.sv
// Front part: takes items, applies fade-in, steps the ring pointers, issues commands.
`default_nettype none
module alfio_front #(
    parameter int DELAY_DEPTH   = alfio_pkg::DELAY_DEPTH_DEF,
    parameter int GAIN_ROM_BITS = alfio_pkg::GAIN_ROM_BITS_DEF,
    parameter int AW            = $clog2(DELAY_DEPTH),
    parameter int CMDW          = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire alfio_pkg::t_cfg   i_cfg,
    input  wire logic              i_clearing,
    input  wire logic              i_push,
    input  wire logic              i_opcode,
    input  wire logic [15:0]       i_sample_0,
    input  wire logic [15:0]       i_sample_1,
    input  wire logic [15:0]       i_sample_2,
    input  wire logic [15:0]       i_sample_3,
    output logic                   o_full,
    output logic                   o_cmd_push,
    output logic [CMDW-1:0]        o_cmd,
    input  wire logic              i_cmd_full
);
    import alfio_pkg::*;

    localparam int CW       = (AW + 1 > 13) ? AW + 1 : 13;
    localparam int ROM_SIZE = 1 << GAIN_ROM_BITS;

    typedef struct packed {
        logic                  pass;
        logic                  rd_en;
        logic                  wr_en;
        logic [AW-1:0]         addr;
        logic [LANES*SW-1:0]   data;
        logic [16:0]           gain;
        logic                  last;
    } t_cmd;

    typedef logic [16:0] t_rom [ROM_SIZE];

    function automatic t_rom build_rom();
        t_rom r;
        for (int k = 0; k < ROM_SIZE; k++) r[k] = gain_rom_entry(k, GAIN_ROM_BITS);
        return r;
    endfunction

    localparam t_rom GainRom = build_rom();

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GAIN = 2'd1;
    localparam logic [1:0] S_WORK = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    logic [1:0]        r_state;
    logic              r_op;
    logic [15:0]       r_raw [LANES];
    logic [16:0]       r_gain;
    logic [AW-1:0]     r_wp;
    logic [AW-1:0]     r_rp;
    logic [16:0]       r_fi_pos;
    logic [24:0]       r_fi_phase;
    logic [CW-1:0]     r_dp;
    logic [24:0]       r_fo_phase;
    t_cmd              r_cmd;

    logic [24:0]       ph;
    logic [36:0]       lin_prod;
    logic [16:0]       gain_calc;
    logic [CW-1:0]     len;
    logic [CW-1:0]     l;
    logic [AW-1:0]     wp0;
    logic [AW-1:0]     rp0;
    logic [CW-1:0]     wp_inc;
    logic [CW-1:0]     rp_inc;
    logic [AW-1:0]     wp1;
    logic [AW-1:0]     rp_nxt;
    logic              hit;
    logic              fading;
    logic [2:0]        nch;
    logic [LANES*SW-1:0] frame;
    logic [15:0]       v;
    logic [25:0]       fi_sum;
    logic              drain_act;
    logic [CW-1:0]     dp_inc;

    assign o_full     = (r_state != S_IDLE) || i_clearing;
    assign o_cmd_push = (r_state == S_PUSH);
    assign o_cmd      = r_cmd;

    always_comb begin
        ph        = r_op ? r_fo_phase : r_fi_phase;
        lin_prod  = {16'd0, ph[20:0]} * {21'd0, LIN_SLOPE};
        if (ph >= UNITY_PHASE) gain_calc = GAIN_ONE;
        else if (ph < LIN_LIMIT) gain_calc = {10'd0, lin_prod[36:30]};
        else gain_calc = GainRom[ph[23 -: GAIN_ROM_BITS]];
    end

    always_comb begin
        len    = CW'(i_cfg.fade_out_length);
        l      = (len > CW'(DELAY_DEPTH)) ? CW'(DELAY_DEPTH) : len;
        wp0    = (CW'(r_wp) >= l) ? '0 : r_wp;
        rp0    = (CW'(r_rp) >= l) ? '0 : r_rp;
        wp_inc = CW'(wp0) + CW'(1);
        rp_inc = CW'(rp0) + CW'(1);
        wp1    = (wp_inc >= l) ? '0 : wp_inc[AW-1:0];
        rp_nxt = (rp_inc >= l) ? '0 : rp_inc[AW-1:0];
        hit    = (wp1 == rp0);
        fading = r_fi_pos < {1'b0, i_cfg.fade_in_length};
        nch    = eff_channels(i_cfg.channel_count);
        for (int c = 0; c < LANES; c++) begin
            v = (3'(c) < nch) ? decode(r_raw[c], i_cfg.sample_format) : 16'd0;
            frame[c*SW +: SW] = fading ? apply_gain(v, r_gain) : v;
        end
        fi_sum    = {1'b0, r_fi_phase} + {1'b0, i_cfg.fade_in_phase_step};
        drain_act = (l != '0) && (r_dp < l);
        dp_inc    = r_dp + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_push && !o_full) begin
            r_op     <= i_opcode;
            r_raw[0] <= i_sample_0;
            r_raw[1] <= i_sample_1;
            r_raw[2] <= i_sample_2;
            r_raw[3] <= i_sample_3;
        end
        if (r_state == S_GAIN) r_gain <= gain_calc;
        if (r_state == S_WORK) begin
            r_cmd.pass  <= !r_op && (l == '0);
            r_cmd.rd_en <= hit;
            r_cmd.wr_en <= (l != '0);
            r_cmd.addr  <= wp1;
            r_cmd.data  <= r_op ? '0 : frame;
            r_cmd.gain  <= r_op ? r_gain : GAIN_ONE;
            r_cmd.last  <= r_op && (dp_inc == l);
        end
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wp       <= '0;
            r_rp       <= '0;
            r_fi_pos   <= '0;
            r_fi_phase <= '0;
            r_dp       <= '0;
            r_fo_phase <= UNITY_PHASE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_push && !o_full) r_state <= S_GAIN;
                S_GAIN: r_state <= S_WORK;
                S_WORK: begin
                    if (!r_op) begin
                        if (fading) r_fi_phase <= (fi_sum > {1'b0, PHASE_MAX}) ?
                                                  PHASE_MAX : fi_sum[24:0];
                        if (r_fi_pos < POS_MAX) r_fi_pos <= r_fi_pos + 17'd1;
                        if (l != '0) begin
                            r_wp <= wp1;
                            r_rp <= hit ? rp_nxt : rp0;
                        end
                        r_state <= S_PUSH;
                    end else if (drain_act) begin
                        r_dp <= dp_inc;
                        r_wp <= wp1;
                        r_rp <= hit ? rp_nxt : rp0;
                        if (hit) r_fo_phase <= (r_fo_phase > i_cfg.fade_out_phase_step) ?
                                 r_fo_phase - i_cfg.fade_out_phase_step : '0;
                        r_state <= S_PUSH;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PUSH: if (!i_cmd_full) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/alfio_back.sv
// Back part: delay store, clearing sweep, fade-out gain, format encoding, result register.
`default_nettype none
module alfio_back #(
    parameter int DELAY_DEPTH = alfio_pkg::DELAY_DEPTH_DEF,
    parameter int AW          = $clog2(DELAY_DEPTH),
    parameter int CMDW        = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire alfio_pkg::t_cfg   i_cfg,
    output logic                   o_clearing,
    input  wire logic [CMDW-1:0]   i_cmd,
    input  wire logic              i_cmd_empty,
    output logic                   o_cmd_pop,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output logic [15:0]            o_out_sample_0,
    output logic [15:0]            o_out_sample_1,
    output logic [15:0]            o_out_sample_2,
    output logic [15:0]            o_out_sample_3,
    output logic                   o_last_frame
);
    import alfio_pkg::*;

    typedef struct packed {
        logic                  pass;
        logic                  rd_en;
        logic                  wr_en;
        logic [AW-1:0]         addr;
        logic [LANES*SW-1:0]   data;
        logic [16:0]           gain;
        logic                  last;
    } t_cmd;

    localparam logic [1:0] B_CLR  = 2'd0;
    localparam logic [1:0] B_IDLE = 2'd1;
    localparam logic [1:0] B_MUL  = 2'd2;
    localparam logic [1:0] B_ENC  = 2'd3;

    logic [LANES*SW-1:0] mem [DELAY_DEPTH];
    logic [LANES*SW-1:0] r_rdata;
    logic [1:0]          r_state;
    logic [AW-1:0]       r_clr;
    t_cmd                r_cmd;
    logic [15:0]         r_lane [LANES];
    logic                r_out_valid;
    logic [15:0]         r_out [LANES];
    logic                r_out_last;

    t_cmd                cmd_in;
    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       mem_addr;
    logic [LANES*SW-1:0] mem_wd;
    logic [LANES*SW-1:0] src;
    logic [2:0]          nch;
    logic                out_free;

    assign cmd_in         = i_cmd;
    assign o_clearing     = (r_state == B_CLR);
    assign o_cmd_pop      = (r_state == B_IDLE) && !i_cmd_empty;
    assign o_empty        = !r_out_valid;
    assign o_out_sample_0 = r_out[0];
    assign o_out_sample_1 = r_out[1];
    assign o_out_sample_2 = r_out[2];
    assign o_out_sample_3 = r_out[3];
    assign o_last_frame   = r_out_last;
    assign out_free       = !r_out_valid || i_pop;
    assign nch            = eff_channels(i_cfg.channel_count);
    assign src            = r_cmd.pass ? r_cmd.data : r_rdata;

    always_comb begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = cmd_in.addr;
        mem_wd   = cmd_in.data;
        if (r_state == B_CLR) begin
            mem_we   = 1'b1;
            mem_addr = r_clr;
            mem_wd   = '0;
        end else if (o_cmd_pop) begin
            mem_we = cmd_in.wr_en;
            mem_re = cmd_in.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) r_rdata <= mem[mem_addr];
        if (mem_we) mem[mem_addr] <= mem_wd;
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) r_cmd <= cmd_in;
        if (r_state == B_MUL) begin
            for (int c = 0; c < LANES; c++) r_lane[c] <= apply_gain(src[c*SW +: SW], r_cmd.gain);
        end
        if (r_state == B_ENC && out_free) begin
            for (int c = 0; c < LANES; c++)
                r_out[c] <= (3'(c) < nch) ? encode(r_lane[c], i_cfg.sample_format) : 16'd0;
            r_out_last <= r_cmd.last;
        end
        if (!i_rst_n) begin
            r_state     <= B_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == B_ENC && out_free) r_out_valid <= 1'b1;
            else if (i_pop) r_out_valid <= 1'b0;
            unique case (r_state)
                B_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DELAY_DEPTH - 1)) r_state <= B_IDLE;
                end
                B_IDLE: if (o_cmd_pop && (cmd_in.pass || cmd_in.rd_en)) r_state <= B_MUL;
                B_MUL:  r_state <= B_ENC;
                B_ENC:  if (out_free) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/audio_log_fade_in_out.sv
// Top level of the exponential fade-in / fade-out stage.
//
//  channel   handshake                 payload
//  input     push / full               i_opcode, i_sample_0..3
//  result    pop / empty               o_out_sample_0..3, o_last_frame
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Front takes an item and steps it through accept, gain look-up, fade-in multiply and
// queue before the next; a drain request after the fade-out has finished skips the queue.
// Back takes a store-only request in idle alone; a result request adds multiply and encode.
// After reset a sweep clears every delay-store entry; full is high meanwhile.
// A held result stalls the back; the 2-entry request queue then fills and raises full.
`default_nettype none
module audio_log_fade_in_out #(
    parameter int DELAY_DEPTH   = alfio_pkg::DELAY_DEPTH_DEF,
    parameter int GAIN_ROM_BITS = alfio_pkg::GAIN_ROM_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_opcode,
    input  wire logic [15:0] i_sample_0,
    input  wire logic [15:0] i_sample_1,
    input  wire logic [15:0] i_sample_2,
    input  wire logic [15:0] i_sample_3,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      o_out_sample_0,
    output logic [15:0]      o_out_sample_1,
    output logic [15:0]      o_out_sample_2,
    output logic [15:0]      o_out_sample_3,
    output logic             o_last_frame,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [24:0] i_cfg_data
);
    import alfio_pkg::*;

    localparam int AW   = $clog2(DELAY_DEPTH);
    localparam int CMDW = 3 + AW + LANES * SW + 17 + 1;

    t_cfg            r_cfg;
    logic            clearing;
    logic            cmd_push;
    logic            cmd_full;
    logic            cmd_pop;
    logic            cmd_empty;
    logic [CMDW-1:0] cmd_in;
    logic [CMDW-1:0] cmd_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count       <= 3'd1;
            r_cfg.sample_format       <= FMT_S16;
            r_cfg.fade_in_length      <= '0;
            r_cfg.fade_out_length     <= '0;
            r_cfg.fade_in_phase_step  <= '0;
            r_cfg.fade_out_phase_step <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CHANNELS: r_cfg.channel_count       <= i_cfg_data[2:0];
                CFG_FORMAT:   r_cfg.sample_format       <= i_cfg_data[1:0];
                CFG_FI_LEN:   r_cfg.fade_in_length      <= i_cfg_data[15:0];
                CFG_FO_LEN:   r_cfg.fade_out_length     <= i_cfg_data[12:0];
                CFG_FI_STEP:  r_cfg.fade_in_phase_step  <= i_cfg_data;
                CFG_FO_STEP:  r_cfg.fade_out_phase_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    alfio_front #(
        .DELAY_DEPTH(DELAY_DEPTH), .GAIN_ROM_BITS(GAIN_ROM_BITS), .AW(AW), .CMDW(CMDW)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_clearing(clearing),
        .i_push(push), .i_opcode(i_opcode),
        .i_sample_0(i_sample_0), .i_sample_1(i_sample_1),
        .i_sample_2(i_sample_2), .i_sample_3(i_sample_3),
        .o_full(full), .o_cmd_push(cmd_push), .o_cmd(cmd_in), .i_cmd_full(cmd_full)
    );

    alfio_cmdq #(.W(CMDW)) u_cmdq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(cmd_push), .i_data(cmd_in), .o_full(cmd_full),
        .i_pop(cmd_pop), .o_data(cmd_out), .o_empty(cmd_empty)
    );

    alfio_back #(.DELAY_DEPTH(DELAY_DEPTH), .AW(AW), .CMDW(CMDW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .o_clearing(clearing),
        .i_cmd(cmd_out), .i_cmd_empty(cmd_empty), .o_cmd_pop(cmd_pop),
        .o_empty(empty), .i_pop(pop),
        .o_out_sample_0(o_out_sample_0), .o_out_sample_1(o_out_sample_1),
        .o_out_sample_2(o_out_sample_2), .o_out_sample_3(o_out_sample_3),
        .o_last_frame(o_last_frame)
    );
endmodule
`default_nettype wire
